@@ rtl/pbc_pkg.sv @@
// PRINCE block cipher package: round constants, S-box, shift-rows and M' layers.
// Shared by the front stage, the queue and the round pipeline. No dependencies.
package pbc_pkg;

    localparam int unsigned BLK_W   = 64;
    localparam int unsigned CFG_W   = 64;
    localparam int unsigned IDX_W   = 1;
    localparam int unsigned NUM_RC  = 12;
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_CNT_W = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_K0 = 1'b0;
    localparam logic [IDX_W-1:0] REG_K1 = 1'b1;

    // operation codes
    localparam logic OP_ENC = 1'b0;
    localparam logic OP_DEC = 1'b1;

    typedef logic [BLK_W-1:0] t_blk;

    // work item handed from front to back: pre-whitened state plus keys
    typedef struct packed {
        t_blk state;
        t_blk k1;
        t_blk kpost;
    } t_work;

    localparam t_blk RC [NUM_RC] = '{
        64'h0000000000000000, 64'h13198a2e03707344, 64'ha4093822299f31d0,
        64'h082efa98ec4e6c89, 64'h452821e638d01377, 64'hbe5466cf34e90c6c,
        64'h7ef84f78fd955cb1, 64'h85840851f1ac43aa, 64'hc882d32f25323c54,
        64'h64a51195e0e3610d, 64'hd3b5a399ca0c2399, 64'hc0ac29b7c97c50dd
    };

    localparam logic [3:0] SBOX_FWD [16] = '{
        4'hB, 4'hF, 4'h3, 4'h2, 4'hA, 4'hC, 4'h9, 4'h1,
        4'h6, 4'h7, 4'h8, 4'h0, 4'hE, 4'h5, 4'hD, 4'h4
    };
    localparam logic [3:0] SBOX_INV [16] = '{
        4'hB, 4'h7, 4'h3, 4'h2, 4'hF, 4'hD, 4'h8, 4'h9,
        4'hA, 4'h6, 4'h4, 4'h0, 4'h5, 4'hE, 4'hC, 4'h1
    };
    localparam logic [3:0] SR_SRC [16] = '{
        4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
        4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11
    };
    localparam logic [3:0] DIAG_MASK [4] = '{4'h7, 4'hB, 4'hD, 4'hE};

    // nibble 0 is the most significant nibble
    function automatic logic [3:0] get_nib(input t_blk x, input logic [3:0] i);
        return x[(4'd15 - i)*4 +: 4];
    endfunction

    function automatic t_blk sub_fwd(input t_blk x);
        t_blk y;
        for (int i = 0; i < 16; i++) y[i*4 +: 4] = SBOX_FWD[x[i*4 +: 4]];
        return y;
    endfunction

    function automatic t_blk sub_inv(input t_blk x);
        t_blk y;
        for (int i = 0; i < 16; i++) y[i*4 +: 4] = SBOX_INV[x[i*4 +: 4]];
        return y;
    endfunction

    function automatic t_blk shift_rows(input t_blk x);
        t_blk y;
        for (int i = 0; i < 16; i++)
            y[(15-i)*4 +: 4] = get_nib(x, SR_SRC[i]);
        return y;
    endfunction

    function automatic t_blk shift_rows_inv(input t_blk x);
        t_blk y;
        y = '0;
        for (int i = 0; i < 16; i++)
            y[(4'd15 - SR_SRC[i])*4 +: 4] = get_nib(x, 4'(i));
        return y;
    endfunction

    function automatic t_blk mprime(input t_blk x);
        t_blk y;
        logic [3:0] acc;
        int off;
        y = '0;
        for (int q = 0; q < 4; q++) begin
            off = (q == 0 || q == 3) ? 0 : 1;
            for (int r = 0; r < 4; r++) begin
                acc = '0;
                for (int c = 0; c < 4; c++)
                    acc ^= get_nib(x, 4'(4*q + c)) & DIAG_MASK[(r + c + off) % 4];
                y[(15 - (4*q + r))*4 +: 4] = acc;
            end
        end
        return y;
    endfunction

endpackage

@@ rtl/pbc_front.sv @@
// PRINCE front stage: takes input beats, picks the direction and pre-whitens.
// Depends on pbc_pkg.
module pbc_front (
    input  logic          i_op,
    input  pbc_pkg::t_blk i_data,
    input  pbc_pkg::t_blk i_k0,
    input  pbc_pkg::t_blk i_k1,
    output pbc_pkg::t_work o_work
);
    import pbc_pkg::*;

    t_blk k2;

    // derived key k2 = ror(k0,1) ^ (k0 >> 63)
    assign k2 = {i_k0[0], i_k0[BLK_W-1:1]} ^ {{(BLK_W-1){1'b0}}, i_k0[BLK_W-1]};

    // classify by direction: decrypt swaps k0/k2 and adds alpha to k1
    always_comb begin
        unique case (i_op)
            OP_DEC: begin
                o_work.state = i_data ^ k2;
                o_work.k1    = i_k1 ^ RC[11];
                o_work.kpost = i_k0;
            end
            default: begin
                o_work.state = i_data ^ i_k0;
                o_work.k1    = i_k1;
                o_work.kpost = k2;
            end
        endcase
    end
endmodule

@@ rtl/pbc_queue.sv @@
// Two-entry queue between the front stage and the round pipeline.
// Depends on pbc_pkg.
module pbc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pbc_pkg::t_work i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output pbc_pkg::t_work o_data
);
    import pbc_pkg::*;

    t_work               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wp, r_rp;
    logic [Q_CNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule

@@ rtl/pbc_core.sv @@
// PRINCE round pipeline: 12 register stages, one round layer group per stage,
// with a stall-all enable and an output register. Depends on pbc_pkg.
module pbc_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pbc_pkg::t_work i_work,
    output logic           o_valid,
    input  logic           i_ready,
    output pbc_pkg::t_blk  o_data
);
    import pbc_pkg::*;

    localparam int unsigned NSTG = 12;

    t_work r_stg [NSTG];
    logic  r_vld [NSTG];
    t_work n_stg [NSTG];
    logic  adv;

    // whole pipe advances unless the last stage holds an untaken result
    assign adv     = !r_vld[NSTG-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[NSTG-1];
    assign o_data  = r_stg[NSTG-1].state;

    // stage 0: k1 ^ RC0; stages 1-5 forward rounds; 6 middle;
    // 7-11 inverse rounds, 11 also adds RC11, k1 and post-whitening
    always_comb begin
        n_stg[0]       = i_work;
        n_stg[0].state = i_work.state ^ i_work.k1 ^ RC[0];
        for (int s = 1; s <= 5; s++) begin
            n_stg[s]       = r_stg[s-1];
            n_stg[s].state = shift_rows(mprime(sub_fwd(r_stg[s-1].state)))
                             ^ RC[s] ^ r_stg[s-1].k1;
        end
        n_stg[6]       = r_stg[5];
        n_stg[6].state = sub_inv(mprime(sub_fwd(r_stg[5].state)));
        for (int s = 7; s <= 10; s++) begin
            n_stg[s]       = r_stg[s-1];
            n_stg[s].state = sub_inv(mprime(shift_rows_inv(
                             r_stg[s-1].state ^ r_stg[s-1].k1 ^ RC[s-1])));
        end
        n_stg[11]       = r_stg[10];
        n_stg[11].state = sub_inv(mprime(shift_rows_inv(
                          r_stg[10].state ^ r_stg[10].k1 ^ RC[10])))
                          ^ RC[11] ^ r_stg[10].k1 ^ r_stg[10].kpost;
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSTG; s++) r_vld[s] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < NSTG; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int s = 0; s < NSTG; s++) r_stg[s] <= n_stg[s];
        end
    end
endmodule

@@ rtl/prince_block_cipher_unit.sv @@
// PRINCE block cipher top level: key registers, front stage, queue, round pipe.
// Depends on pbc_pkg, pbc_front, pbc_queue, pbc_core.
//
// Usage:
//  - Configuration: i_cfg_we with i_cfg_idx 0 writes k0 (whitening key), 1 writes
//    k1 (core key). Write only while the block is idle.
//  - Input stream s_axis: tdata = data_in (64 bits), tuser = op (0 enc, 1 dec).
//  - Output stream m_axis: tdata = data_out (64 bits), one beat per input beat.
//  - Throughput: one beat per cycle while m_axis_tready is high, set by the
//    12-stage unrolled round pipe. Path: an accepted beat is registered in the
//    queue, then in round stages 0 to 11; the last stage drives the output.
//  - Stall: when m_axis_tready is low and a result waits at the output, the
//    round pipe freezes; the two-entry queue absorbs beats and s_axis_tready
//    drops once it is full.
//  - Reset: synchronous active low; clears both keys to zero and drops all
//    beats in flight.
module prince_block_cipher_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pbc_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [pbc_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [63:0]                s_axis_tdata,  // [63:0] data_in
    input  logic                       s_axis_tuser,  // [0] op
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [63:0]                m_axis_tdata   // [63:0] data_out
);
    import pbc_pkg::*;

    t_blk  r_k0, r_k1;
    t_work front_work, q_work;
    logic  q_full, q_valid, q_pop, core_ready, push;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k0 <= '0;
            r_k1 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_K0:  r_k0 <= i_cfg_data;
                default: r_k1 <= i_cfg_data;
            endcase
        end
    end

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;
    assign q_pop         = q_valid && core_ready;

    pbc_front u_front (
        .i_op   (s_axis_tuser),
        .i_data (s_axis_tdata),
        .i_k0   (r_k0),
        .i_k1   (r_k1),
        .o_work (front_work)
    );

    pbc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (front_work),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_work)
    );

    pbc_core u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .o_ready(core_ready),
        .i_work (q_work),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_data (m_axis_tdata)
    );

    // a stalled result must hold
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");

    // queue never accepts while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push)
        else $error("queue overflow");

    // the pipe takes queue entries only when the queue has one
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");
endmodule

@@ sim/tb_prince_checker.sv @@
// Checker for the PRINCE cipher unit: predicts each output block from the
// accepted input beats and the current keys. Depends on pbc_pkg.
`timescale 1ns / 100ps

module tb_prince_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_in_data,
    input  logic        i_in_op,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_out_data,
    output int          o_errors,
    output int          o_pending
);
    import pbc_pkg::*;

    localparam logic [63:0] ROUND_CONST [12] = '{
        64'h0000000000000000, 64'h13198a2e03707344, 64'ha4093822299f31d0,
        64'h082efa98ec4e6c89, 64'h452821e638d01377, 64'hbe5466cf34e90c6c,
        64'h7ef84f78fd955cb1, 64'h85840851f1ac43aa, 64'hc882d32f25323c54,
        64'h64a51195e0e3610d, 64'hd3b5a399ca0c2399, 64'hc0ac29b7c97c50dd
    };
    localparam logic [3:0] S_FWD [16] = '{
        4'hB, 4'hF, 4'h3, 4'h2, 4'hA, 4'hC, 4'h9, 4'h1,
        4'h6, 4'h7, 4'h8, 4'h0, 4'hE, 4'h5, 4'hD, 4'h4
    };
    localparam logic [3:0] S_INV [16] = '{
        4'hB, 4'h7, 4'h3, 4'h2, 4'hF, 4'hD, 4'h8, 4'h9,
        4'hA, 4'h6, 4'h4, 4'h0, 4'h5, 4'hE, 4'hC, 4'h1
    };
    localparam int ROW_SRC [16] = '{0, 5, 10, 15, 4, 9, 14, 3, 8, 13, 2, 7, 12, 1, 6, 11};
    localparam logic [3:0] MIX_MASK [4] = '{4'h7, 4'hB, 4'hD, 4'hE};

    logic [63:0] key_white;
    logic [63:0] key_core;
    logic [63:0] expected_blocks [$];

    // nibble 0 is the top nibble
    function automatic logic [3:0] nib(input logic [63:0] x, input int i);
        return x[(15 - i)*4 +: 4];
    endfunction

    function automatic logic [63:0] subst(input logic [63:0] x, input bit inv);
        logic [63:0] y;
        for (int i = 0; i < 16; i++)
            y[i*4 +: 4] = inv ? S_INV[x[i*4 +: 4]] : S_FWD[x[i*4 +: 4]];
        return y;
    endfunction

    function automatic logic [63:0] rows(input logic [63:0] x, input bit inv);
        logic [63:0] y;
        for (int i = 0; i < 16; i++)
            if (inv) y[(15 - ROW_SRC[i])*4 +: 4] = nib(x, i);
            else     y[(15 - i)*4 +: 4] = nib(x, ROW_SRC[i]);
        return y;
    endfunction

    function automatic logic [63:0] mix(input logic [63:0] x);
        logic [63:0] y;
        logic [3:0] acc;
        int off;
        for (int q = 0; q < 4; q++) begin
            off = (q == 0 || q == 3) ? 0 : 1;
            for (int r = 0; r < 4; r++) begin
                acc = '0;
                for (int c = 0; c < 4; c++)
                    acc ^= nib(x, 4*q + c) & MIX_MASK[(r + c + off) % 4];
                y[(15 - (4*q + r))*4 +: 4] = acc;
            end
        end
        return y;
    endfunction

    // full PRINCE: whitening around the core; decrypt swaps k0/k2, k1 ^ alpha
    function automatic logic [63:0] prince_predict(input logic [63:0] blk,
                                                   input logic op);
        logic [63:0] k2, kin, kout, kc, s;
        k2 = {key_white[0], key_white[63:1]} ^ {63'd0, key_white[63]};
        kin  = (op == OP_DEC) ? k2 : key_white;
        kout = (op == OP_DEC) ? key_white : k2;
        kc   = (op == OP_DEC) ? key_core ^ ROUND_CONST[11] : key_core;
        s = blk ^ kin ^ kc;
        for (int i = 1; i <= 5; i++)
            s = rows(mix(subst(s, 1'b0)), 1'b0) ^ ROUND_CONST[i] ^ kc;
        s = subst(mix(subst(s, 1'b0)), 1'b1);
        for (int i = 6; i <= 10; i++)
            s = subst(mix(rows(s ^ kc ^ ROUND_CONST[i], 1'b1)), 1'b1);
        return s ^ ROUND_CONST[11] ^ kc ^ kout;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_pending = expected_blocks.size();

    // track keys, queue predictions, compare output beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_white <= '0;
            key_core  <= '0;
            expected_blocks.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_K0) key_white <= i_cfg_data;
                else                     key_core  <= i_cfg_data;
            end
            if (i_in_valid && i_in_ready)
                expected_blocks.push_back(prince_predict(i_in_data, i_in_op));
            if (i_out_valid && i_out_ready) begin
                if (expected_blocks.size() == 0)
                    report_mismatch($sformatf("unexpected beat %h", i_out_data));
                else begin
                    if (i_out_data !== expected_blocks[0])
                        report_mismatch($sformatf("data_out %h, want %h",
                                                  i_out_data, expected_blocks[0]));
                    void'(expected_blocks.pop_front());
                end
            end
        end
    end
endmodule

@@ sim/tb_top.sv @@
// Testbench top for prince_block_cipher_unit: clock, reset, key phases, stimulus
// and verdict. Depends on pbc_pkg, tb_prince_checker and the RTL.
`timescale 1ns / 100ps

module tb_top;
    import pbc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = REG_K0;
    logic [63:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tuser = OP_ENC;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    int          err_count, pending;
    int          cycles = 0;
    bit          quiet_phase = 0;
    bit          long_hold = 0;

    prince_block_cipher_unit u_dut (.*);

    tb_prince_checker u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_op(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .o_errors(err_count), .o_pending(pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (60) @(posedge i_clk);
                long_hold = 0;
            end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 11);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic write_key(input logic idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one beat, optionally preceded by a random gap
    task automatic send_block(input logic op, input logic [63:0] blk, input bit gaps);
        if (gaps && !quiet_phase && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= blk;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial begin
        logic [63:0] keys [5][2];
        keys = '{'{64'h0, 64'h0}, '{'1, '1}, '{64'h0, 64'h0123456789abcdef},
                 '{64'h0, 64'h0}, '{64'h0, 64'h0}};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset keys, known vectors and field extremes, both directions
        send_block(OP_ENC, 64'h0, 0);
        send_block(OP_DEC, 64'h0, 0);
        send_block(OP_ENC, '1, 0);
        send_block(OP_DEC, '1, 0);
        send_block(OP_ENC, 64'h8000000000000001, 0);
        wait_drained();
        for (int k = 1; k < 3; k++) begin
            write_key(REG_K0, keys[k][0]);
            write_key(REG_K1, keys[k][1]);
            send_block(OP_ENC, 64'h0, 0);
            send_block(OP_ENC, '1, 0);
            send_block(OP_DEC, 64'h0, 0);
            send_block(OP_DEC, '1, 0);
            send_block(OP_ENC, 64'h0123456789abcdef, 0);
            wait_drained();
        end

        // random phases with random keys
        for (int ph = 0; ph < 6; ph++) begin
            write_key(REG_K0, rand64());
            write_key(REG_K1, rand64());
            if (ph == 2) long_hold = 1;
            if (ph == 5) quiet_phase = 1;
            for (int i = 0; i < 105; i++) begin
                send_block(1'($urandom_range(0, 1)), rand64(), 1);
                // one sender pause until everything has come back
                if (ph == 3 && i == 50) wait_drained();
            end
            wait_drained();
        end

        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
